>>> sv/filled_circle_span_generator_defines.svh
// Assertion macros used by the filled circle span generator datapath
`ifndef FILLED_CIRCLE_SPAN_GENERATOR_DEFINES_SVH
`define FILLED_CIRCLE_SPAN_GENERATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define FCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/fcs_pkg.sv
// Package: shared constants, state type and control structs of the span generator
`default_nettype none

package fcs_pkg;

  localparam int CoordW  = 14;
  localparam int SpanXyW = 15;
  localparam int RadiusW = 5;
  localparam int ColorW  = 8;
  localparam int WidthW  = 6;
  localparam int SquareW = 2 * RadiusW;
  localparam int BitIdxW = 3;
  localparam int InDataW  = 64;
  localparam int OutDataW = 64;
  localparam int OutPackW = 2 * SpanXyW + WidthW + 3 * ColorW;

  localparam logic [RadiusW-1:0] MAX_RADIUS = 5'd31;
  localparam logic [BitIdxW-1:0] RootMsb    = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_ROOT,
    ST_EMIT_LO,
    ST_EMIT_HI
  } fcs_state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic root_step;
    logic emit;
    logic emit_hi;
    logic next_row;
  } fcs_cmd_t;

  typedef struct packed {
    logic row_zero;
    logic row_last;
    logic root_done;
    logic out_free;
  } fcs_sts_t;

endpackage

`default_nettype wire

>>> sv/fcs_ctrl.sv
// Controller: sequences row preparation, square root steps and span emission
`default_nettype none

module fcs_ctrl
  import fcs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire fcs_sts_t sts,
  output fcs_cmd_t      cmd
);

  fcs_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.root_done) begin
          state_next = ST_EMIT_LO;
        end
      end
      ST_EMIT_LO: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (!sts.row_zero) begin
            state_next = ST_EMIT_HI;
          end else if (sts.row_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.next_row = 1'b1;
            state_next   = ST_PREP;
          end
        end
      end
      ST_EMIT_HI: begin
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.emit_hi = 1'b1;
          if (sts.row_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.next_row = 1'b1;
            state_next   = ST_PREP;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/fcs_dp.sv
// Datapath: request hold, row counter, bitwise square root and span output register
`default_nettype none

`include "filled_circle_span_generator_defines.svh"

module fcs_dp
  import fcs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [InDataW-1:0]  in_data,
  input  wire fcs_cmd_t            cmd,
  output fcs_sts_t                 sts,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [OutDataW-1:0]      out_data,
  output logic                     out_last
);

  logic [CoordW-1:0]     cx;
  logic [CoordW-1:0]     cy;
  logic [RadiusW-1:0]    rad;
  logic [3*ColorW-1:0]   color;
  logic [RadiusW-1:0]    row;
  logic [SquareW-1:0]    num;
  logic [RadiusW-1:0]    res;
  logic [BitIdxW-1:0]    bit_idx;
  logic [OutPackW-1:0]   span;

  logic [RadiusW-1:0]    in_radius;
  logic [RadiusW-1:0]    rad_cap;
  logic [RadiusW-1:0]    cand;
  logic [SquareW-1:0]    cand_sq;
  logic [SquareW-1:0]    num_next;
  logic [SpanXyW-1:0]    span_x;
  logic [SpanXyW-1:0]    span_y;
  logic [WidthW-1:0]     span_w;
  logic                  span_last;

  assign in_radius = in_data[2*CoordW +: RadiusW];
  assign rad_cap   = (in_radius > MAX_RADIUS) ? MAX_RADIUS : in_radius;

  assign cand     = res | (RadiusW'(1) << bit_idx);
  assign cand_sq  = {{RadiusW{1'b0}}, cand} * {{RadiusW{1'b0}}, cand};
  assign num_next = {{RadiusW{1'b0}}, rad} * {{RadiusW{1'b0}}, rad}
                  - {{RadiusW{1'b0}}, row} * {{RadiusW{1'b0}}, row};

  assign span_x = {cx[CoordW-1], cx} - {{(SpanXyW-RadiusW){1'b0}}, res};
  assign span_y = cmd.emit_hi ? ({cy[CoordW-1], cy} + {{(SpanXyW-RadiusW){1'b0}}, row})
                              : ({cy[CoordW-1], cy} - {{(SpanXyW-RadiusW){1'b0}}, row});
  assign span_w = {res, 1'b0};
  assign span_last = cmd.emit_hi ? (row == rad) : ((row == rad) && (row == '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      rad <= '0;
      row <= '0;
    end else if (cmd.load) begin
      rad <= rad_cap;
      row <= '0;
    end else if (cmd.next_row) begin
      row <= row + RadiusW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx    <= in_data[0 +: CoordW];
      cy    <= in_data[CoordW +: CoordW];
      color <= in_data[2*CoordW+RadiusW +: 3*ColorW];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      num     <= num_next;
      res     <= '0;
      bit_idx <= RootMsb;
    end else if (cmd.root_step) begin
      if (cand_sq <= num) begin
        res <= cand;
      end
      bit_idx <= bit_idx - BitIdxW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      span     <= {color, span_w, span_y, span_x};
      out_last <= span_last;
    end
  end

  assign out_data = {{(OutDataW-OutPackW){1'b0}}, span};

  assign sts.row_zero  = (row == '0);
  assign sts.row_last  = (row == rad);
  assign sts.root_done = (bit_idx == '0);
  assign sts.out_free  = !out_valid || out_ready;

  `FCS_ASSERT_NOW(a_emit_free, clk, rst, cmd.emit, sts.out_free,
    "span loaded over an untaken span")
  `FCS_ASSERT_NOW(a_row_bound, clk, rst, 1'b1, row <= rad,
    "row offset beyond radius")
  `FCS_ASSERT_NEXT(a_root_floor, clk, rst, cmd.root_step && sts.root_done,
    ({{RadiusW{1'b0}}, res} * {{RadiusW{1'b0}}, res}) <= num,
    "square root exceeds its operand")

endmodule

`default_nettype wire

>>> sv/filled_circle_span_generator.sv
// Top level: filled circle span generator, controller plus datapath
// The first span is registered after the prep state and the square root steps.
// Each row takes a setup step, 5 root steps and 2 spans (one for the center row);
//   a span waits while the output register still holds an untaken span.
// A new request is taken once the last span is loaded, even while it waits.
// Synchronous reset idles the controller and empties the output register.
`default_nettype none

module filled_circle_span_generator
  import fcs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // center_x[13:0], center_y[27:14], radius[32:28], red[40:33],
  // green[48:41], blue[56:49], zero fill [63:57]
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // span_x[14:0], span_y[29:15], span_width[35:30], span_red[43:36],
  // span_green[51:44], span_blue[59:52], zero fill [63:60]
  output logic [OutDataW-1:0]      m_axis_tdata,
  output logic                     m_axis_tlast
);

  fcs_cmd_t cmd;
  fcs_sts_t sts;

  fcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fcs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

`default_nettype wire

>>> dv/tb_filled_circle_span_generator.sv
// Testbench for filled_circle_span_generator: random circle requests, predicted spans, scoreboard
`timescale 1ns / 100ps

module tb_filled_circle_span_generator;
  import fcs_pkg::*;

  typedef struct packed {
    logic [SpanXyW-1:0] x;
    logic [SpanXyW-1:0] y;
    logic [WidthW-1:0]  width;
    logic [ColorW-1:0]  red;
    logic [ColorW-1:0]  green;
    logic [ColorW-1:0]  blue;
    logic               last;
  } span_t;

  class span_scoreboard;
    span_t pending_spans[$];
    int    mismatches;
    int    circles;
    int    spans_checked;

    function int pending();
      return pending_spans.size();
    endfunction

    function void note_circle(logic [InDataW-1:0] req);
      int    cx;
      int    cy;
      int    rad;
      int    h;
      int    rows;
      span_t sp;
      cx  = $signed(req[CoordW-1:0]);
      cy  = $signed(req[2*CoordW-1:CoordW]);
      rad = req[2*CoordW+RadiusW-1:2*CoordW];
      if (rad > MAX_RADIUS) begin
        rad = MAX_RADIUS;
      end
      sp.red   = req[2*CoordW+RadiusW+ColorW-1:2*CoordW+RadiusW];
      sp.green = req[2*CoordW+RadiusW+2*ColorW-1:2*CoordW+RadiusW+ColorW];
      sp.blue  = req[2*CoordW+RadiusW+3*ColorW-1:2*CoordW+RadiusW+2*ColorW];
      for (int d = 0; d <= rad; d++) begin
        h = 0;
        while ((h + 1) * (h + 1) <= rad * rad - d * d) begin
          h++;
        end
        rows = (d == 0) ? 1 : 2;
        for (int s = 0; s < rows; s++) begin
          sp.x     = SpanXyW'(cx - h);
          sp.y     = SpanXyW'((d == 0) ? cy : ((s == 0) ? cy - d : cy + d));
          sp.width = WidthW'(2 * h);
          sp.last  = (d == rad) && (s == rows - 1);
          pending_spans.push_back(sp);
        end
      end
      circles++;
    endfunction

    function void compare_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $display("%0t: span %0d %s expected %0d actual %0d",
                 $time, spans_checked, name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_span(logic [OutDataW-1:0] data, logic last);
      span_t exp_sp;
      span_t act_sp;
      act_sp.x     = data[SpanXyW-1:0];
      act_sp.y     = data[2*SpanXyW-1:SpanXyW];
      act_sp.width = data[2*SpanXyW+WidthW-1:2*SpanXyW];
      act_sp.red   = data[2*SpanXyW+WidthW+ColorW-1:2*SpanXyW+WidthW];
      act_sp.green = data[2*SpanXyW+WidthW+2*ColorW-1:2*SpanXyW+WidthW+ColorW];
      act_sp.blue  = data[2*SpanXyW+WidthW+3*ColorW-1:2*SpanXyW+WidthW+2*ColorW];
      act_sp.last  = last;
      if (pending_spans.size() == 0) begin
        $display("%0t: unexpected span expected none actual %h last %b", $time, data, last);
        mismatches++;
        return;
      end
      exp_sp = pending_spans.pop_front();
      compare_field("span_x", $signed(exp_sp.x), $signed(act_sp.x));
      compare_field("span_y", $signed(exp_sp.y), $signed(act_sp.y));
      compare_field("span_width", exp_sp.width, act_sp.width);
      compare_field("span_red", exp_sp.red, act_sp.red);
      compare_field("span_green", exp_sp.green, act_sp.green);
      compare_field("span_blue", exp_sp.blue, act_sp.blue);
      compare_field("last_span", exp_sp.last, act_sp.last);
      spans_checked++;
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  span_scoreboard sb;
  bit             burst_phase;
  int             rx_hold_cycles;

  filled_circle_span_generator uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("tb_filled_circle_span_generator: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      sb.note_circle(s_axis_tdata);
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_span(m_axis_tdata, m_axis_tlast);
    end
  end

  function automatic logic [InDataW-1:0] make_request(int cx, int cy, int rad,
                                                      int red, int green, int blue);
    logic [InDataW-1:0] req;
    req = '0;
    req[CoordW-1:0]                     = CoordW'(cx);
    req[2*CoordW-1:CoordW]              = CoordW'(cy);
    req[2*CoordW+RadiusW-1:2*CoordW]    = RadiusW'(rad);
    req[2*CoordW+RadiusW+ColorW-1:2*CoordW+RadiusW] = ColorW'(red);
    req[2*CoordW+RadiusW+2*ColorW-1:2*CoordW+RadiusW+ColorW]   = ColorW'(green);
    req[2*CoordW+RadiusW+3*ColorW-1:2*CoordW+RadiusW+2*ColorW] = ColorW'(blue);
    return req;
  endfunction

  task automatic send_request(logic [InDataW-1:0] req);
    int gap;
    gap = burst_phase ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= req;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // receiver: random back-pressure per item outside the burst phase, plus long hold-offs on request
  initial begin
    int gap;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      gap = burst_phase ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  initial begin
    int cx;
    int cy;
    int rad;
    sb = new();
    burst_phase = 1'b0;
    rx_hold_cycles = 0;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(make_request(0, 0, 0, 0, 0, 0));
    send_request(make_request(-8192, 8191, 0, 255, 255, 255));
    send_request(make_request(5, -7, 1, 1, 2, 4));
    send_request(make_request(-8192, -8192, 31, 255, 0, 255));
    send_request(make_request(8191, 8191, 31, 0, 255, 0));
    send_request(make_request(-8192, 8191, 31, 170, 85, 170));
    send_request(make_request(8191, -8192, 31, 85, 170, 85));
    send_request(make_request(100, 200, 2, 128, 64, 32));
    send_request(make_request(-100, -200, 3, 16, 8, 1));
    send_request(make_request(8190, -8191, 5, 255, 255, 0));
    send_request(make_request(-1, -1, 16, 0, 0, 255));
    send_request(make_request(8191, 8191, 1, 255, 255, 255));
    send_request(make_request(-8192, -8192, 1, 0, 0, 0));
    send_request(make_request(0, 0, 30, 127, 128, 129));

    for (int i = 0; i < 280; i++) begin
      burst_phase = (i >= 60 && i < 110);
      if (i == 140) begin
        rx_hold_cycles = 400;
      end
      if (i == 200) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
      case ($urandom_range(0, 7))
        0: cx = -8192;
        1: cx = 8191;
        default: cx = $signed(CoordW'($urandom));
      endcase
      case ($urandom_range(0, 7))
        0: cy = -8192;
        1: cy = 8191;
        default: cy = $signed(CoordW'($urandom));
      endcase
      case ($urandom_range(0, 9))
        0: rad = 0;
        1: rad = 31;
        2, 3, 4: rad = $urandom_range(0, 4);
        default: rad = $urandom_range(0, 31);
      endcase
      send_request(make_request(cx, cy, rad, $urandom_range(0, 255),
                                $urandom_range(0, 255), $urandom_range(0, 255)));
    end
    s_axis_tvalid <= 1'b0;
    burst_phase = 1'b0;

    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d circles (radius 0 to 31, coordinate extremes, stalls) and %0d spans",
             sb.circles, sb.spans_checked);
    $display("%0d field mismatches, %0d spans still expected", sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_filled_circle_span_generator: PASS");
    end else begin
      $display("tb_filled_circle_span_generator: FAIL");
    end
    $finish;
  end

endmodule
